>>> rtl/core/rtnb_pkg.sv
package rtnb_pkg;

    // Depth of the key and id stores; the slot port addresses all of it.
    localparam int MAX_KEYS = 1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SELF,
        ST_NB_P,
        ST_NB_M,
        ST_SPAN,
        ST_BIN,
        ST_NODE,
        ST_SPLIT
    } state_t;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Leading-zero count of a 64-bit word, 64 when zero.
    function automatic logic [6:0] lz64(input logic [63:0] x);
        logic [6:0] c;
        logic       found;
        c     = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (x[i] && !found) begin
                c     = 7'(63 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/radix_tree_node_builder.sv
// Radix tree node builder. Write requests (mode 0) store a sorted Morton key
// and its primitive id and produce no result. Query requests (mode 1)
// compute one internal node of a Karras linear BVH and produce exactly one
// result, shown for a single cycle with done high. The receiver cannot
// stall: the result must be captured in the cycle done is high. A query
// whose slot is not an internal node (slot >= key_count - 1) never raises
// busy; its result, with status 1, appears in the cycle after the request
// is taken. Any other query raises busy from the edge that takes it and
// makes one key-memory read per cycle: the slot and its two neighbours,
// k = 1 to 3 span probes (128, 512, 2048 in the chosen direction), b = 8,
// 10 or 12 binary-search probes for the far end (log2 of the final span
// plus one), one read of the far end, and m = 0 to 10 split probes (about
// log2 of the range length). Busy falls at the same edge that raises done.
// There is no clearing pass; entries that were never written must not be
// covered by key_count.
module radix_tree_node_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [9:0]  slot,
    input  logic [63:0] morton_key,
    input  logic [9:0]  prim_id,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    output logic        done,
    output logic [10:0] left_node,
    output logic [10:0] right_node,
    output logic [9:0]  range_first,
    output logic [9:0]  range_last,
    output logic [9:0]  split_pos,
    output logic        status
);
    import rtnb_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    // Signed position arithmetic wide enough for span overshoot.
    localparam int PW = 16;
    localparam logic signed [PW-1:0] POS_ONE    = PW'(1);
    localparam logic [PW-1:0]        SPAN_START = PW'(128);
    localparam logic [10:0]          COUNT_MAX  = 11'(MAX_KEYS);

    // The stores are only written while idle; only reads during a query are used,
    // so a read and a write that meet on the same entry never affect a result.
    logic [63:0] key_mem [MAX_KEYS];
    logic [9:0]  id_mem  [MAX_KEYS];

    state_t state_reg, state_next;
    logic [10:0] count_reg;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        bad_reg, bad_next;

    logic signed [PW-1:0] slot_reg, slot_next;
    logic                 dir_neg_reg, dir_neg_next;
    logic signed [7:0]    pp_reg, pp_next;
    logic signed [7:0]    floor_reg, floor_next;
    logic signed [7:0]    node_reg, node_next;
    logic [PW-1:0]        span_reg, span_next;
    logic [PW-1:0]        len_reg, len_next;
    logic [PW-1:0]        t_reg, t_next;
    logic [PW-1:0]        s_reg, s_next;
    logic [PW-1:0]        step_reg, step_next;
    logic [63:0]          self_key_reg, self_key_next;
    logic [9:0]           self_id_reg, self_id_next;

    logic [63:0] rd_key_reg;
    logic [9:0]  rd_id_reg;
    logic        rd_ok_reg;

    logic signed [PW-1:0] cnt_s;
    logic signed [PW-1:0] slot_in;
    logic                 slot_bad;
    logic                 accept;
    logic                 accept_q;
    logic                 wr_en;

    always_comb begin
        if (count_reg > COUNT_MAX)
            cnt_s = $signed(PW'(COUNT_MAX));
        else
            cnt_s = $signed(PW'(count_reg));
    end

    assign slot_in  = $signed(PW'(slot));
    // Every query is out of range when fewer than two keys are in use.
    assign slot_bad = (slot_in >= cnt_s - POS_ONE);
    assign accept   = start && !busy_reg;
    assign accept_q = accept && (mode == MODE_QUERY);
    assign wr_en    = accept && (mode == MODE_WRITE);

    // Prefix length of the slot's own key against the key read last cycle.
    // A position outside the keys in use counts as -1; equal keys fall back
    // to 64 plus the leading zeros of the 32-bit id difference.
    logic [63:0]       kx;
    logic [31:0]       ix;
    logic [6:0]        id_lz;
    logic signed [7:0] pfx;
    always_comb begin
        kx    = self_key_reg ^ rd_key_reg;
        ix    = {22'd0, self_id_reg ^ rd_id_reg};
        id_lz = lz64({ix, 32'hFFFF_FFFF});
        if (!rd_ok_reg)
            pfx = -8'sd1;
        else if (kx != 64'd0)
            pfx = $signed({1'b0, lz64(kx)});
        else
            pfx = 8'sd64 + $signed({1'b0, id_lz});
    end

    logic          hit;
    logic [PW-1:0] len_new;
    logic [PW-1:0] first_step;
    logic [PW-1:0] cand;
    logic          take;
    logic [PW-1:0] s_new;
    logic [PW-1:0] step_new;

    assign hit        = (pfx > floor_reg);
    assign len_new    = hit ? len_reg + t_reg : len_reg;
    assign first_step = (len_reg + PW'(1)) >> 1;
    assign cand       = s_reg + step_reg;
    assign take       = (cand < len_reg) && (pfx > node_reg);
    assign s_new      = take ? cand : s_reg;
    assign step_new   = (step_reg == PW'(1)) ? '0 : (step_reg + PW'(1)) >> 1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept_q && !slot_bad) state_next = ST_SELF;
            ST_SELF:  state_next = ST_NB_P;
            ST_NB_P:  state_next = ST_NB_M;
            ST_NB_M:  state_next = ST_SPAN;
            ST_SPAN:  if (!hit) state_next = ST_BIN;
            ST_BIN:   if (t_reg == PW'(1)) state_next = ST_NODE;
            ST_NODE:  state_next = (first_step == '0) ? ST_IDLE : ST_SPLIT;
            ST_SPLIT: if (step_reg == PW'(1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Iteration registers and the offset of the next key-memory probe. Each
    // state compares the key that its own probe returned and issues the
    // probe of the state that follows.
    logic signed [PW-1:0] probe_base;
    logic [PW-1:0]        probe_off;
    logic                 probe_neg;

    always_comb begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        bad_next      = bad_reg;
        slot_next     = slot_reg;
        dir_neg_next  = dir_neg_reg;
        pp_next       = pp_reg;
        floor_next    = floor_reg;
        node_next     = node_reg;
        span_next     = span_reg;
        len_next      = len_reg;
        t_next        = t_reg;
        s_next        = s_reg;
        step_next     = step_reg;
        self_key_next = self_key_reg;
        self_id_next  = self_id_reg;
        probe_off     = '0;
        probe_neg     = dir_neg_reg;
        case (state_reg)
            ST_IDLE: begin
                probe_neg = 1'b0;
                if (accept_q) begin
                    slot_next = slot_in;
                    bad_next  = slot_bad;
                    if (slot_bad)
                        done_next = 1'b1;
                    else
                        busy_next = 1'b1;
                end
            end
            ST_SELF: begin
                self_key_next = rd_key_reg;
                self_id_next  = rd_id_reg;
                probe_off     = PW'(1);
                probe_neg     = 1'b0;
            end
            ST_NB_P: begin
                pp_next   = pfx;
                probe_off = PW'(1);
                probe_neg = 1'b1;
            end
            ST_NB_M: begin
                // A tie between the two neighbours goes upward.
                dir_neg_next = !(pp_reg >= pfx);
                floor_next   = (pp_reg >= pfx) ? pfx : pp_reg;
                span_next    = SPAN_START;
                probe_off    = SPAN_START;
                probe_neg    = !(pp_reg >= pfx);
            end
            ST_SPAN: begin
                if (hit) begin
                    span_next = span_reg << 2;
                    probe_off = span_reg << 2;
                end else begin
                    t_next    = span_reg;
                    len_next  = '0;
                    probe_off = span_reg;
                end
            end
            ST_BIN: begin
                len_next = len_new;
                t_next   = t_reg >> 1;
                if (t_reg == PW'(1))
                    probe_off = len_new;
                else
                    probe_off = len_new + (t_reg >> 1);
            end
            ST_NODE: begin
                node_next = pfx;
                s_next    = '0;
                step_next = first_step;
                probe_off = first_step;
                if (first_step == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            ST_SPLIT: begin
                s_next    = s_new;
                step_next = step_new;
                probe_off = s_new + step_new;
                if (step_reg == PW'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    logic signed [PW-1:0] probe_pos;
    logic                 probe_ok;
    logic [AW-1:0]        rd_addr;

    assign probe_base = (state_reg == ST_IDLE) ? slot_in : slot_reg;
    assign probe_pos  = probe_neg ? probe_base - $signed(probe_off)
                                  : probe_base + $signed(probe_off);
    assign probe_ok   = (probe_pos >= 0) && (probe_pos < cnt_s);
    assign rd_addr    = probe_pos[AW-1:0];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            key_mem[slot] <= morton_key;
            id_mem[slot]  <= prim_id;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_id_reg  <= id_mem[rd_addr];
        rd_ok_reg  <= probe_ok;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            bad_reg   <= bad_next;
            if (cfg_we)
                count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk) begin
        slot_reg     <= slot_next;
        dir_neg_reg  <= dir_neg_next;
        pp_reg       <= pp_next;
        floor_reg    <= floor_next;
        node_reg     <= node_next;
        span_reg     <= span_next;
        len_reg      <= len_next;
        t_reg        <= t_next;
        s_reg        <= s_next;
        step_reg     <= step_next;
        self_key_reg <= self_key_next;
        self_id_reg  <= self_id_next;
    end

    // The result is formed from the registers that the search left behind;
    // they hold still through the result cycle.
    logic signed [PW-1:0] far_pos, lo_pos, hi_pos, split_p;
    logic signed [PW-1:0] left_wide, right_wide;
    logic                 show;

    assign far_pos    = dir_neg_reg ? slot_reg - $signed(len_reg) : slot_reg + $signed(len_reg);
    assign lo_pos     = (slot_reg < far_pos) ? slot_reg : far_pos;
    assign hi_pos     = (slot_reg > far_pos) ? slot_reg : far_pos;
    assign split_p    = dir_neg_reg ? slot_reg - $signed(s_reg) - POS_ONE
                                    : slot_reg + $signed(s_reg);
    assign left_wide  = (lo_pos == split_p) ? split_p : cnt_s + split_p;
    assign right_wide = (hi_pos == split_p + POS_ONE) ? split_p + POS_ONE
                                                      : cnt_s + split_p + POS_ONE;
    assign show       = done_reg && !bad_reg;

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = done_reg && bad_reg;
    assign left_node   = show ? left_wide[10:0]  : 11'd0;
    assign right_node  = show ? right_wide[10:0] : 11'd0;
    assign range_first = show ? lo_pos[9:0]      : 10'd0;
    assign range_last  = show ? hi_pos[9:0]      : 10'd0;
    assign split_pos   = show ? split_p[9:0]     : 10'd0;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE) && !busy)
        else $error("result outside idle");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done || $past(start)))
        else $error("result repeated");
    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy == (state_reg != ST_IDLE))
        else $error("busy out of step with the search");
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !status) |-> (range_first <= range_last))
        else $error("range ends reversed");

endmodule

>>> tb/radix_tree_node_builder_tb.sv
module radix_tree_node_builder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtnb_pkg::*;

    // Slots in the block's key and id stores.
    localparam int STORE_DEPTH = 1024;
    // Cycles allowed for the whole run before it is declared hung.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Quiet cycles given to the block after the last result, and before a
    // key_count write, so that a write still in flight can settle.
    localparam int SETTLE_CYCLES = 8;
    // Rough number of requests for the random part.
    localparam int RANDOM_REQUESTS = 1300;

    // One internal node as the block reports it.
    typedef struct packed {
        logic [10:0] left_child;
        logic [10:0] right_child;
        logic [9:0]  first_leaf;
        logic [9:0]  last_leaf;
        logic [9:0]  split;
        logic        not_internal;
    } node_t;

    // A row of the directed table is either a key_count write or a request.
    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        mode;
        logic [9:0]  slot;
        logic [63:0] key;
        logic [9:0]  id;
        bit          literal;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [9:0]  slot;
    logic [63:0] morton_key;
    logic [9:0]  prim_id;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        done;
    logic [10:0] left_node;
    logic [10:0] right_node;
    logic [9:0]  range_first;
    logic [9:0]  range_last;
    logic [9:0]  split_pos;
    logic        status;

    // Shadow copy of the block's stores and of the key_count register, kept
    // in step with every accepted write.
    logic [63:0] shadow_keys [STORE_DEPTH];
    logic [9:0]  shadow_ids  [STORE_DEPTH];
    int          tree_leaves;

    // Nodes still owed by the block, oldest first.
    node_t       pending_nodes[$];
    int          fail_count;
    int          cycle_count;
    int          sent_requests;

    radix_tree_node_builder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .slot       (slot),
        .morton_key (morton_key),
        .prim_id    (prim_id),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .left_node  (left_node),
        .right_node (right_node),
        .range_first(range_first),
        .range_last (range_last),
        .split_pos  (split_pos),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Hang guard: nothing in a correct run comes near this limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Number of leading zeros of a 64-bit word; 64 for zero.
    function automatic int leading_zeros(input logic [63:0] word);
        int n;
        n = 0;
        while (n < 64 && !word[63 - n])
            n++;
        return n;
    endfunction

    // Common prefix length of the leaves at positions a and b. A position
    // outside the leaves in use counts as -1. Equal keys fall back to the ids,
    // which are compared as 32-bit words; the trailing ones cap the count at 32.
    function automatic int common_prefix(input int a, input int b);
        logic [63:0] diff;
        if (a < 0 || a >= tree_leaves || b < 0 || b >= tree_leaves)
            return -1;
        diff = shadow_keys[a] ^ shadow_keys[b];
        if (diff != 64'd0)
            return leading_zeros(diff);
        return 64 + leading_zeros({22'd0, shadow_ids[a] ^ shadow_ids[b], 32'hFFFF_FFFF});
    endfunction

    // Karras construction of one internal node: pick the direction from the
    // neighbours, grow the range by powers of four, binary search its far
    // end, then binary search the split inside it.
    function automatic node_t build_node(input int node);
        node_t result;
        int    dir;
        int    floor_len;
        int    reach;
        int    span_len;
        int    far_end;
        int    node_len;
        int    offset;
        int    step;
        int    split;
        int    lo;
        int    hi;
        result = '0;
        if (node >= tree_leaves - 1)
        begin
            result.not_internal = 1'b1;
            return result;
        end
        dir = (common_prefix(node, node + 1) >= common_prefix(node, node - 1)) ? 1 : -1;
        floor_len = common_prefix(node, node - dir);
        reach = 128;
        while (common_prefix(node, node + reach * dir) > floor_len)
            reach *= 4;
        span_len = 0;
        for (int t = reach; t >= 1; t /= 2)
            if (common_prefix(node, node + (span_len + t) * dir) > floor_len)
                span_len += t;
        far_end = node + span_len * dir;
        node_len = common_prefix(node, far_end);
        offset = 0;
        step = (span_len + 1) / 2;
        while (step >= 1)
        begin
            if (offset + step < span_len
                && common_prefix(node, node + (offset + step) * dir) > node_len)
                offset += step;
            step = (step == 1) ? 0 : (step + 1) / 2;
        end
        split = node + offset * dir - (dir < 0 ? 1 : 0);
        lo = (node < far_end) ? node : far_end;
        hi = (node > far_end) ? node : far_end;
        result.left_child  = 11'((lo == split) ? split : tree_leaves + split);
        result.right_child = 11'((hi == split + 1) ? split + 1 : tree_leaves + split + 1);
        result.first_leaf  = 10'(lo);
        result.last_leaf   = 10'(hi);
        result.split       = 10'(split);
        return result;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Results are valid for the single cycle that done is high; they are
    // taken at the edge that ends that cycle.
    always @(posedge clk)
    begin
        node_t want;
        if (rst_n && done)
        begin
            if (pending_nodes.size() == 0)
            begin
                $error("result with no query outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_nodes.pop_front();
                check_field("left_node",   want.left_child,   left_node);
                check_field("right_node",  want.right_child,  right_node);
                check_field("range_first", want.first_leaf,   range_first);
                check_field("range_last",  want.last_leaf,    range_last);
                check_field("split_pos",   want.split,        split_pos);
                check_field("status",      want.not_internal, status);
            end
        end
    end

    // Sends one request after a random gap and waits until the block takes
    // it. When the gap is zero start stays high from the previous request.
    // A literal row expects the plain "not an internal node" answer.
    task automatic send_request(input logic req_mode, input logic [9:0] req_slot,
                                input logic [63:0] req_key, input logic [9:0] req_id,
                                input bit literal);
        int    gap;
        node_t not_node;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= req_mode;
        slot       <= req_slot;
        morton_key <= req_key;
        prim_id    <= req_id;
        do
            @(posedge clk);
        while (busy);
        sent_requests++;
        if (req_mode == MODE_WRITE)
        begin
            shadow_keys[req_slot] = req_key;
            shadow_ids[req_slot]  = req_id;
        end
        else if (literal)
        begin
            not_node = '0;
            not_node.not_internal = 1'b1;
            pending_nodes.push_back(not_node);
        end
        else
            pending_nodes.push_back(build_node(req_slot));
    endtask

    // key_count is only changed with the block idle: every node delivered
    // and then SETTLE_CYCLES quiet cycles for a trailing write.
    task automatic set_key_count(input logic [10:0] value);
        start <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tree_leaves = (value > STORE_DEPTH) ? STORE_DEPTH : int'(value);
    endtask

    // One random phase: a fresh key set of the given size, then queries mixed
    // with the odd rewrite of a leaf in use and some out-of-range queries.
    task automatic run_phase(input int leaves, input int queries);
        int          style;
        logic [63:0] key;
        logic [9:0]  id_base;
        int          pick;
        style   = $urandom_range(0, 3);
        key     = {$urandom, $urandom} >> $urandom_range(1, 12);
        id_base = 10'($urandom);
        set_key_count(11'(leaves));
        for (int i = 0; i < leaves; i++)
        begin
            case (style)
                0: send_request(MODE_WRITE, 10'(i), {$urandom, $urandom}, 10'($urandom), 0);
                1: begin
                    // Heavy duplication: many equal keys, ids from a small set.
                    if ($urandom_range(0, 3) == 0)
                        key = key + $urandom_range(1, 3);
                    send_request(MODE_WRITE, 10'(i), key,
                                 id_base ^ 10'($urandom_range(0, 3)), 0);
                end
                default: begin
                    if ($urandom_range(0, 2) != 0)
                        key = key + ({$urandom, $urandom} >> $urandom_range(11, 63));
                    send_request(MODE_WRITE, 10'(i), key, 10'($urandom), 0);
                end
            endcase
        end
        for (int q = 0; q < queries; q++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_request(MODE_WRITE, 10'($urandom_range(0, leaves - 1)),
                             {$urandom, $urandom}, 10'($urandom), 0);
            else if (pick == 1)
                send_request(MODE_QUERY, 10'($urandom_range(leaves - 1, STORE_DEPTH - 1)),
                             {$urandom, $urandom}, 10'($urandom), 0);
            else
                send_request(MODE_QUERY, 10'($urandom_range(0, leaves - 2)),
                             {$urandom, $urandom}, 10'($urandom), 0);
        end
    endtask

    initial
    begin
        row_t table_rows [20];
        int   leaves;

        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_WRITE;
        slot        = '0;
        morton_key  = '0;
        prim_id     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        tree_leaves = 0;
        fail_count  = 0;
        cycle_count = 0;
        sent_requests = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. With no leaves every query is out of range. The
        // six leaves hold an all-zero key twice with the same id (prefix of
        // 96), three equal keys with ids that tie the direction test, and
        // the all-ones key with the largest id.
        table_rows = '{
            '{ROW_REQ, MODE_QUERY, 10'd0,    64'd0, 10'd0, 1},
            '{ROW_REQ, MODE_QUERY, 10'd1023, 64'd0, 10'd0, 1},
            '{ROW_REQ, MODE_WRITE, 10'd0,    64'd0, 10'd0, 0},
            '{ROW_REQ, MODE_WRITE, 10'd1,    64'd0, 10'd0, 0},
            '{ROW_REQ, MODE_WRITE, 10'd2,    64'd7, 10'd1, 0},
            '{ROW_REQ, MODE_WRITE, 10'd3,    64'd7, 10'd0, 0},
            '{ROW_REQ, MODE_WRITE, 10'd4,    64'd7, 10'd1, 0},
            '{ROW_REQ, MODE_WRITE, 10'd5,    64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 0},
            '{ROW_CFG, MODE_WRITE, 10'd0,    64'd1, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd0,    64'd0, 10'd0, 1},
            '{ROW_CFG, MODE_WRITE, 10'd0,    64'd6, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd0,    64'd0, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd1,    64'd0, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd2,    64'd0, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd3,    64'd0, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd4,    64'd0, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd5,    64'd0, 10'd0, 1},
            '{ROW_REQ, MODE_QUERY, 10'd1023, 64'd0, 10'd0, 1},
            // A count above the store size saturates; only the last slot is
            // out of range then, and it is the only one safe to query.
            '{ROW_CFG, MODE_WRITE, 10'd0,    64'd2047, 10'd0, 0},
            '{ROW_REQ, MODE_QUERY, 10'd1023, 64'd0, 10'd0, 1}
        };
        foreach (table_rows[r])
        begin
            if (table_rows[r].kind == ROW_CFG)
                set_key_count(11'(table_rows[r].key));
            else
                send_request(table_rows[r].mode, table_rows[r].slot, table_rows[r].key,
                             table_rows[r].id, table_rows[r].literal);
        end

        // Random part: mostly small trees, starting with the smallest one,
        // then a single full-size tree at the end.
        leaves = 2;
        while (sent_requests < RANDOM_REQUESTS - 1200)
        begin
            run_phase(leaves, 2 * leaves + 4);
            leaves = $urandom_range(2, 40);
        end
        run_phase(STORE_DEPTH, 120);

        start <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
